// ===== rtl/madt_apic_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the MADT APIC id table.
package madt_apic_pkg;

    // table geometry
    localparam int MAX_CPUS = 64;
    localparam int IDX_W    = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;
    localparam int FILL_W   = $clog2(MAX_CPUS + 1);
    localparam int ID_W     = 8;

    // stream word widths
    localparam int IN_W     = 24;
    localparam int OUT_W    = 40;
    localparam int OUT_USED = 33;

    // MADT layout
    localparam logic [ID_W-1:0] EMPTY_ID   = 8'hff;
    localparam logic [31:0]     HDR_LEN    = 32'd44;
    localparam logic [31:0]     SAT32      = 32'hffff_ffff;
    localparam logic [7:0]      LAPIC_TYPE = 8'd0;
    localparam logic [7:0]      MIN_SUB    = 8'd2;
    localparam logic [7:0]      MIN_LAPIC  = 8'd5;
    localparam logic [31:0]     MIN_IMAGE  = 32'd8;

    // request codes
    localparam logic [1:0] REQ_BYTE = 2'd0;
    localparam logic [1:0] REQ_FWD  = 2'd1;
    localparam logic [1:0] REQ_REV  = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NO_CPU = 2'd1;
    localparam logic [1:0] ST_TRUNC  = 2'd2;

    // which result the output register takes
    typedef enum logic [1:0] {
        OUT_END,
        OUT_FWD,
        OUT_REV_HIT,
        OUT_REV_MISS
    } t_out_kind;

    // controller to datapath
    typedef struct packed {
        logic      load;
        logic      byte_a;
        logic      byte_b;
        logic      fin;
        logic      ram_rd;
        logic      scan_next;
        logic      out_load;
        t_out_kind out_kind;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic last;
        logic rev_done;
        logic rev_hit;
    } t_sts;

endpackage

// ===== rtl/madt_apic_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module madt_apic_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                       i_wr_data,
    input  logic                                   i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                       o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read, hold data between reads
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/madt_apic_dp.sv =====
// Datapath: MADT walk registers, id RAM with fill count, lookup scan and output register.
module madt_apic_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [madt_apic_pkg::IN_W-1:0]    i_s_tdata,
    input  logic [1:0]                        i_s_tuser,
    input  logic                              i_s_tlast,
    input  madt_apic_pkg::t_cmd               i_cmd,
    output madt_apic_pkg::t_sts               o_sts,
    output logic [madt_apic_pkg::OUT_W-1:0]   o_m_tdata
);

    localparam int IW = madt_apic_pkg::IDX_W;
    localparam int FW = madt_apic_pkg::FILL_W;
    localparam int PAD_W = madt_apic_pkg::OUT_W - madt_apic_pkg::OUT_USED;

    // captured input word
    logic [7:0]  r_data;
    logic [7:0]  r_cidx;
    logic [7:0]  r_query;
    logic        r_last;
    logic [1:0]  r_req;

    // walk state
    logic [31:0] r_offset,      n_offset;
    logic [31:0] r_table_len,   n_table_len;
    logic [31:0] r_entry_start, n_entry_start;
    logic [7:0]  r_entry_kind,  n_entry_kind;
    logic [7:0]  r_entry_size,  n_entry_size;
    logic [7:0]  r_captured_id, n_captured_id;
    logic        r_stopped,     n_stopped;
    logic [15:0] r_seen,        n_seen;
    logic [FW-1:0] r_fill,      n_fill;

    // first-phase results of a byte
    logic [31:0] r_rel,         n_rel;
    logic        r_in_walk,     n_in_walk;
    logic        r_start_ge_len, n_start_ge_len;

    // reverse scan index
    logic [FW-1:0] r_scan;

    // output register
    logic [1:0]  r_out_status;
    logic [15:0] r_out_count;
    logic        r_out_found;
    logic [5:0]  r_out_cpu;
    logic [7:0]  r_out_apic;

    // combinational helpers
    logic [32:0] diff;
    logic [32:0] start_sum;
    logic [7:0]  size_eff;
    logic        rel_is0;
    logic        rel_is1;
    logic        end_of_sub;
    logic        stop_now;
    logic        ram_we;
    logic [IW-1:0] rd_addr;
    logic [7:0]  rd_data;
    logic        fwd_hit;
    logic        rev_hit;
    logic [1:0]  end_status;

    // capture the accepted word
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_data  <= i_s_tdata[7:0];
            r_cidx  <= i_s_tdata[15:8];
            r_query <= i_s_tdata[23:16];
            r_last  <= i_s_tlast;
            r_req   <= i_s_tuser;
        end
    end

    assign diff       = {1'b0, r_offset} - {1'b0, r_entry_start};
    assign rel_is0    = (r_rel == 32'd0);
    assign rel_is1    = (r_rel == 32'd1);
    assign size_eff   = rel_is1 ? r_data : r_entry_size;
    assign start_sum  = {1'b0, r_entry_start} + {25'd0, size_eff};
    assign end_of_sub = (r_rel[31:8] != 24'd0) ||
                        (({1'b0, r_rel[7:0]} + 9'd1) >= {1'b0, size_eff});

    // next state of the walk
    always_comb begin
        n_offset       = r_offset;
        n_table_len    = r_table_len;
        n_entry_start  = r_entry_start;
        n_entry_kind   = r_entry_kind;
        n_entry_size   = r_entry_size;
        n_captured_id  = r_captured_id;
        n_stopped      = r_stopped;
        n_seen         = r_seen;
        n_fill         = r_fill;
        n_rel          = r_rel;
        n_in_walk      = r_in_walk;
        n_start_ge_len = r_start_ge_len;
        stop_now       = 1'b0;
        ram_we         = 1'b0;

        // phase one: offset within the current subtable
        if (i_cmd.byte_a) begin
            n_rel          = diff[31:0];
            n_in_walk      = !r_stopped && !diff[32];
            n_start_ge_len = (r_entry_start >= r_table_len);
        end

        // phase two: apply the byte
        if (i_cmd.byte_b) begin
            if ((r_offset[31:3] == 29'd0) && r_offset[2]) begin
                n_table_len = r_table_len | ({24'd0, r_data} << {r_offset[1:0], 3'b000});
            end
            if (r_in_walk) begin
                if (rel_is0) begin
                    if (r_start_ge_len) begin
                        stop_now = 1'b1;
                    end else begin
                        n_entry_kind = r_data;
                    end
                end else if (rel_is1) begin
                    n_entry_size = r_data;
                    if (r_data < madt_apic_pkg::MIN_SUB) begin
                        stop_now = 1'b1;
                    end
                end else begin
                    if (r_rel == 32'd3) begin
                        n_captured_id = r_data;
                    end
                    if ((r_rel == 32'd4) && (r_entry_kind == madt_apic_pkg::LAPIC_TYPE) &&
                        (r_entry_size >= madt_apic_pkg::MIN_LAPIC) && r_data[0]) begin
                        if (r_seen < 16'(madt_apic_pkg::MAX_CPUS)) begin
                            ram_we = 1'b1;
                            if (r_seen >= 16'(r_fill)) begin
                                n_fill = FW'(r_seen + 16'd1);
                            end
                        end
                        n_seen = r_seen + 16'd1;
                    end
                end
                if (!stop_now && !rel_is0 && end_of_sub) begin
                    n_entry_start = start_sum[32] ? madt_apic_pkg::SAT32 : start_sum[31:0];
                end
                n_stopped = r_stopped | stop_now;
            end
            n_offset = (r_offset == madt_apic_pkg::SAT32) ? madt_apic_pkg::SAT32 :
                       r_offset + 32'd1;
        end

        // end of image: restart the walk, keep the id table
        if (i_cmd.fin) begin
            n_offset      = 32'd0;
            n_table_len   = 32'd0;
            n_entry_start = madt_apic_pkg::HDR_LEN;
            n_entry_kind  = 8'd0;
            n_entry_size  = 8'd0;
            n_captured_id = 8'd0;
            n_stopped     = 1'b0;
            n_seen        = 16'd0;
        end
    end

    // hold walk state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset       <= 32'd0;
            r_table_len    <= 32'd0;
            r_entry_start  <= madt_apic_pkg::HDR_LEN;
            r_entry_kind   <= 8'd0;
            r_entry_size   <= 8'd0;
            r_captured_id  <= 8'd0;
            r_stopped      <= 1'b0;
            r_seen         <= 16'd0;
            r_fill         <= '0;
            r_rel          <= 32'd0;
            r_in_walk      <= 1'b0;
            r_start_ge_len <= 1'b0;
        end else begin
            r_offset       <= n_offset;
            r_table_len    <= n_table_len;
            r_entry_start  <= n_entry_start;
            r_entry_kind   <= n_entry_kind;
            r_entry_size   <= n_entry_size;
            r_captured_id  <= n_captured_id;
            r_stopped      <= n_stopped;
            r_seen         <= n_seen;
            r_fill         <= n_fill;
            r_rel          <= n_rel;
            r_in_walk      <= n_in_walk;
            r_start_ge_len <= n_start_ge_len;
        end
    end

    // advance the reverse scan
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_scan <= '0;
        end else if (i_cmd.scan_next) begin
            r_scan <= r_scan + FW'(1);
        end
    end

    // id table
    assign rd_addr = (r_req == madt_apic_pkg::REQ_REV) ? r_scan[IW-1:0] : r_cidx[IW-1:0];

    madt_apic_ram #(
        .WIDTH (madt_apic_pkg::ID_W),
        .DEPTH (madt_apic_pkg::MAX_CPUS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (r_seen[IW-1:0]),
        .i_wr_data (r_captured_id),
        .i_rd_en   (i_cmd.ram_rd),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // lookup and end-of-image decisions
    assign fwd_hit = ({1'b0, r_cidx} < 9'(r_fill)) && (rd_data != madt_apic_pkg::EMPTY_ID);
    assign rev_hit = (rd_data == r_query) && (rd_data != madt_apic_pkg::EMPTY_ID);

    always_comb begin
        if ((r_offset < madt_apic_pkg::MIN_IMAGE) || (r_offset < r_table_len)) begin
            end_status = madt_apic_pkg::ST_TRUNC;
        end else if (r_seen == 16'd0) begin
            end_status = madt_apic_pkg::ST_NO_CPU;
        end else begin
            end_status = madt_apic_pkg::ST_OK;
        end
    end

    // load the output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            case (i_cmd.out_kind)
                madt_apic_pkg::OUT_END: begin
                    r_out_status <= end_status;
                    r_out_count  <= r_seen;
                    r_out_found  <= 1'b0;
                    r_out_cpu    <= 6'd0;
                    r_out_apic   <= 8'd0;
                end
                madt_apic_pkg::OUT_FWD: begin
                    r_out_status <= madt_apic_pkg::ST_OK;
                    r_out_count  <= 16'd0;
                    r_out_found  <= fwd_hit;
                    r_out_cpu    <= 6'd0;
                    r_out_apic   <= fwd_hit ? rd_data : 8'd0;
                end
                madt_apic_pkg::OUT_REV_HIT: begin
                    r_out_status <= madt_apic_pkg::ST_OK;
                    r_out_count  <= 16'd0;
                    r_out_found  <= 1'b1;
                    r_out_cpu    <= 6'(r_scan);
                    r_out_apic   <= 8'd0;
                end
                madt_apic_pkg::OUT_REV_MISS: begin
                    r_out_status <= madt_apic_pkg::ST_OK;
                    r_out_count  <= 16'd0;
                    r_out_found  <= 1'b0;
                    r_out_cpu    <= 6'(madt_apic_pkg::MAX_CPUS - 1);
                    r_out_apic   <= 8'd0;
                end
                default: begin
                    r_out_status <= madt_apic_pkg::ST_OK;
                    r_out_count  <= 16'd0;
                    r_out_found  <= 1'b0;
                    r_out_cpu    <= 6'd0;
                    r_out_apic   <= 8'd0;
                end
            endcase
        end
    end

    assign o_sts.last     = r_last;
    assign o_sts.rev_done = (r_scan == r_fill);
    assign o_sts.rev_hit  = rev_hit;

    assign o_m_tdata = {{PAD_W{1'b0}}, r_out_apic, r_out_cpu, r_out_found,
                        r_out_count, r_out_status};

endmodule

// ===== rtl/madt_apic_ctrl.sv =====
// Controller: sequences table bytes, forward lookups and reverse scans, owns output valid.
module madt_apic_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    input  logic [1:0]          i_s_tuser,
    output logic                o_s_tready,
    input  logic                i_m_tready,
    output logic                o_m_tvalid,
    input  madt_apic_pkg::t_sts i_sts,
    output madt_apic_pkg::t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_BYTE_A,
        S_BYTE_B,
        S_FIN,
        S_FWD_RD,
        S_FWD_OUT,
        S_REV_RD,
        S_REV_CHK
    } t_state;

    t_state r_state;
    logic   r_m_tvalid;
    logic   slot_free;
    logic   accept;

    assign slot_free  = !r_m_tvalid || i_m_tready;
    assign o_s_tready = (r_state == S_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;

    // commands per state
    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.load = i_s_tvalid;
            end
            S_BYTE_A: begin
                o_cmd.byte_a = 1'b1;
            end
            S_BYTE_B: begin
                o_cmd.byte_b = 1'b1;
            end
            S_FIN: begin
                if (slot_free) begin
                    o_cmd.fin      = 1'b1;
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_kind = madt_apic_pkg::OUT_END;
                end
            end
            S_FWD_RD: begin
                o_cmd.ram_rd = 1'b1;
            end
            S_FWD_OUT: begin
                if (slot_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_kind = madt_apic_pkg::OUT_FWD;
                end
            end
            S_REV_RD: begin
                if (i_sts.rev_done) begin
                    if (slot_free) begin
                        o_cmd.out_load = 1'b1;
                        o_cmd.out_kind = madt_apic_pkg::OUT_REV_MISS;
                    end
                end else begin
                    o_cmd.ram_rd = 1'b1;
                end
            end
            S_REV_CHK: begin
                if (i_sts.rev_hit) begin
                    if (slot_free) begin
                        o_cmd.out_load = 1'b1;
                        o_cmd.out_kind = madt_apic_pkg::OUT_REV_HIT;
                    end
                end else begin
                    o_cmd.scan_next = 1'b1;
                end
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    // hold state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_m_tvalid <= 1'b0;
        end else begin
            if (o_cmd.out_load) begin
                r_m_tvalid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_tvalid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        case (i_s_tuser)
                            madt_apic_pkg::REQ_BYTE: r_state <= S_BYTE_A;
                            madt_apic_pkg::REQ_FWD:  r_state <= S_FWD_RD;
                            madt_apic_pkg::REQ_REV:  r_state <= S_REV_RD;
                            default:                 r_state <= S_IDLE;
                        endcase
                    end
                end
                S_BYTE_A: begin
                    r_state <= S_BYTE_B;
                end
                S_BYTE_B: begin
                    r_state <= i_sts.last ? S_FIN : S_IDLE;
                end
                S_FIN, S_FWD_OUT: begin
                    if (slot_free) begin
                        r_state <= S_IDLE;
                    end
                end
                S_FWD_RD: begin
                    r_state <= S_FWD_OUT;
                end
                S_REV_RD: begin
                    if (i_sts.rev_done) begin
                        if (slot_free) begin
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_state <= S_REV_CHK;
                    end
                end
                S_REV_CHK: begin
                    if (i_sts.rev_hit) begin
                        if (slot_free) begin
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_state <= S_REV_RD;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_m_tvalid;

endmodule

// ===== rtl/madt_local_apic_id_table_top.sv =====
// Top level: MADT local APIC id table with byte stream input and lookup results.
//
//  channel | dir | tdata (low bit up)                          | tuser     | tlast
//  s       | in  | data_byte, cpu_index, apic_query            | req_type  | last_byte
//  m       | out | status, enabled_count, found, cpu_result,   | -         | -
//          |     | apic_result, zero pad to 40 bits            |           |
//
// A table byte passes through phase one and phase two before the next ready; the last byte of an
// image adds a step that loads the end result. A forward lookup reads the id RAM
// through its registered read and then loads the result. A reverse lookup scans the filled entries
// through the one RAM read port, with a read and a check per entry: it stops at the first hit,
// and reports a miss once all filled entries have been checked.
// Reset needs no clearing pass: a fill count marks which id entries were written.
// A result waits in the output register; the block keeps accepting words and only
// holds in its final step when a second result would overwrite an untaken one.
module madt_local_apic_id_table_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // [7:0] data_byte, [15:8] cpu_index, [23:16] apic_query
    input  logic [madt_apic_pkg::IN_W-1:0]  i_s_tdata,
    // [1:0] req_type
    input  logic [1:0]                      i_s_tuser,
    input  logic                            i_s_tlast,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // [1:0] status, [17:2] enabled_count, [18] found, [24:19] cpu_result,
    // [32:25] apic_result, [39:33] zero
    output logic [madt_apic_pkg::OUT_W-1:0] o_m_tdata
);

    madt_apic_pkg::t_cmd cmd;
    madt_apic_pkg::t_sts sts;

    madt_apic_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tuser  (i_s_tuser),
        .o_s_tready (o_s_tready),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    madt_apic_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tdata (i_s_tdata),
        .i_s_tuser (i_s_tuser),
        .i_s_tlast (i_s_tlast),
        .i_cmd     (cmd),
        .o_sts     (sts),
        .o_m_tdata (o_m_tdata)
    );

endmodule

// ===== rtl/madt_apic_chk.sv =====
// Port-level checker for the MADT APIC id table, bound to the top level.
module madt_apic_chk (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    input  logic                            o_s_tready,
    input  logic [madt_apic_pkg::IN_W-1:0]  i_s_tdata,
    input  logic [1:0]                      i_s_tuser,
    input  logic                            i_s_tlast,
    input  logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    input  logic [madt_apic_pkg::OUT_W-1:0] o_m_tdata
);

    // stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result dropped while stalled");

    // stalled result word holds
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata))
        else $error("result word changed while stalled");

    // a valid request keeps the block busy in the next cycle
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && (i_s_tuser != 2'd3) |=> !o_s_tready)
        else $error("ready right after a valid request");

    // a forward lookup cannot answer in the next cycle
    a_fwd_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && (i_s_tuser == madt_apic_pkg::REQ_FWD) && !o_m_tvalid
        |=> !o_m_tvalid)
        else $error("forward lookup answered before the id read");

endmodule

bind madt_local_apic_id_table_top madt_apic_chk u_chk (.*);
